[sv/polar_bin_nearest_point_core_defines.svh]
// ----------------------------------------------------------------------------
// polar bin nearest point core - assertion macros
// shared property forms for the core and its sub-blocks
// ----------------------------------------------------------------------------
`ifndef POLAR_BIN_NEAREST_POINT_CORE_DEFINES_SVH
`define POLAR_BIN_NEAREST_POINT_CORE_DEFINES_SVH

// same-cycle implication
`define PBNP_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PBNP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/pbnp_pkg.sv]
// ----------------------------------------------------------------------------
// pbnp_pkg
// shared constants, command codes, cordic angle table and control types
// ----------------------------------------------------------------------------
package pbnp_pkg;

    localparam int BIN_COUNT_DEF  = 720;
    localparam int COORD_BITS_DEF = 20;
    localparam int ANGLE_BITS_DEF = 16;

    localparam int CORDIC_STEPS   = 16;
    localparam int ITER_W         = $clog2(CORDIC_STEPS);
    localparam int BIN_INDEX_BITS = 10;
    localparam int CMD_W          = 2;

    localparam int CFG_DATA_W     = 64;
    localparam int CFG_ADDR_W     = 4;

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_READ   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_NOP    = 2'd3;

    localparam logic REG_MIN_RANGE_SQ = 1'b0;

    localparam logic [31:0] ACC_START = 32'h8000_0000;

    typedef struct packed {
        logic start;
    } t_cordic_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_cordic_sts;

    // atan(2^-i) in units of 2^-32 turn
    function automatic logic [31:0] atan_turn(input logic [ITER_W-1:0] idx);
        logic [31:0] v;
        case (idx)
            4'd0:    v = 32'h2000_0000;
            4'd1:    v = 32'h12E4_051E;
            4'd2:    v = 32'h09FB_385B;
            4'd3:    v = 32'h0511_11D4;
            4'd4:    v = 32'h028B_0D43;
            4'd5:    v = 32'h0145_D7E1;
            4'd6:    v = 32'h00A2_F61E;
            4'd7:    v = 32'h0051_7C55;
            4'd8:    v = 32'h0028_BE53;
            4'd9:    v = 32'h0014_5F2F;
            4'd10:   v = 32'h000A_2F98;
            4'd11:   v = 32'h0005_17CC;
            4'd12:   v = 32'h0002_8BE6;
            4'd13:   v = 32'h0001_45F3;
            4'd14:   v = 32'h0000_A2FA;
            4'd15:   v = 32'h0000_517D;
            default: v = 32'h0000_0000;
        endcase
        return v;
    endfunction

endpackage

[sv/polar_bin_nearest_point_core.sv]
// ----------------------------------------------------------------------------
// polar_bin_nearest_point_core
// nearest point per bearing bin, with cordic bearing and ram-backed bins
// ----------------------------------------------------------------------------
// One command is handled at a time; o_in_ready is high only while the core is
// idle, and a finished result waits in the output register while the next
// beat is taken. An insert runs through these steps from accept to the next
// accept: square and sum, a threshold check, the cordic (16 iterations of one
// shared shift/add stage plus its done strobe), the bin multiply, one bin ram
// read and the compare/write back. An insert at or below the threshold skips
// from the check to the result; a clear writes every bin through the ram's
// single port. After reset the core sweeps all BIN_COUNT bins (720 by default)
// of the bin ram once with o_in_ready low; configuration writes are taken
// meanwhile.
`include "polar_bin_nearest_point_core_defines.svh"

module polar_bin_nearest_point_core #(
    parameter int BIN_COUNT  = pbnp_pkg::BIN_COUNT_DEF,
    parameter int COORD_BITS = pbnp_pkg::COORD_BITS_DEF,
    parameter int ANGLE_BITS = pbnp_pkg::ANGLE_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [pbnp_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [pbnp_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [pbnp_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                                pready,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [pbnp_pkg::CMD_W-1:0]          i_command,
    input  logic signed [COORD_BITS-1:0]        i_x_coord,
    input  logic signed [COORD_BITS-1:0]        i_y_coord,
    input  logic signed [COORD_BITS-1:0]        i_z_coord,
    input  logic [pbnp_pkg::BIN_INDEX_BITS-1:0] i_bin_index,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic                                o_accepted,
    output logic                                o_bin_filled,
    output logic signed [COORD_BITS-1:0]        o_nearest_x,
    output logic signed [COORD_BITS-1:0]        o_nearest_y,
    output logic signed [COORD_BITS-1:0]        o_nearest_z,
    output logic [2*COORD_BITS-1:0]             o_nearest_range_sq
);
    import pbnp_pkg::*;

    localparam int RANGE_W = 2 * COORD_BITS;
    localparam int ENTRY_W = RANGE_W + 3 * COORD_BITS;
    localparam int BIN_W   = (BIN_COUNT > 1) ? $clog2(BIN_COUNT) : 1;
    localparam int BIN_CW  = $clog2(BIN_COUNT + 1);
    localparam int CMPW    = (BIN_CW > BIN_INDEX_BITS) ? BIN_CW : BIN_INDEX_BITS;
    localparam int PROD_W  = ANGLE_BITS + BIN_CW;

    localparam logic [ENTRY_W-1:0] EMPTY_ENTRY = {{RANGE_W{1'b1}}, {(3*COORD_BITS){1'b0}}};

    localparam logic [3:0] ST_CLEAR  = 4'd0;
    localparam logic [3:0] ST_IDLE   = 4'd1;
    localparam logic [3:0] ST_SQUARE = 4'd2;
    localparam logic [3:0] ST_SUM    = 4'd3;
    localparam logic [3:0] ST_CHECK  = 4'd4;
    localparam logic [3:0] ST_CORDIC = 4'd5;
    localparam logic [3:0] ST_BIN    = 4'd6;
    localparam logic [3:0] ST_LOOKUP = 4'd7;
    localparam logic [3:0] ST_UPDATE = 4'd8;
    localparam logic [3:0] ST_RESULT = 4'd9;

    logic [3:0]                  r_state;
    logic [3:0]                  n_state;
    logic [BIN_W-1:0]            r_clr_addr;
    logic                        r_clr_cmd;
    logic [CMD_W-1:0]            r_cmd;
    logic signed [COORD_BITS-1:0] r_x;
    logic signed [COORD_BITS-1:0] r_y;
    logic signed [COORD_BITS-1:0] r_z;
    logic [RANGE_W-1:0]          r_xx;
    logic [RANGE_W-1:0]          r_yy;
    logic [RANGE_W-1:0]          r_range;
    logic [PROD_W-1:0]           r_prod;
    logic [BIN_W-1:0]            r_bin;
    logic                        r_oob;

    logic                        r_res_accepted;
    logic                        r_res_filled;
    logic signed [COORD_BITS-1:0] r_res_x;
    logic signed [COORD_BITS-1:0] r_res_y;
    logic signed [COORD_BITS-1:0] r_res_z;
    logic [RANGE_W-1:0]          r_res_range;

    logic                        r_out_valid;
    logic                        r_out_accepted;
    logic                        r_out_filled;
    logic signed [COORD_BITS-1:0] r_out_x;
    logic signed [COORD_BITS-1:0] r_out_y;
    logic signed [COORD_BITS-1:0] r_out_z;
    logic [RANGE_W-1:0]          r_out_range;

    logic [RANGE_W-1:0]          w_min_range_sq;
    logic [COORD_BITS-1:0]       w_ax;
    logic [COORD_BITS-1:0]       w_ay;
    logic [RANGE_W-1:0]          w_xx;
    logic [RANGE_W-1:0]          w_yy;
    logic                        w_skip;
    logic [ANGLE_BITS-1:0]       w_angle;
    logic [BIN_CW-1:0]           w_bin_raw;
    logic [BIN_W-1:0]            w_bin;
    logic [ENTRY_W-1:0]          w_rdata;
    logic [RANGE_W-1:0]          w_rd_range;
    logic                        w_better;
    logic                        w_filled;
    logic                        w_ram_we;
    logic [BIN_W-1:0]            w_ram_addr;
    logic [ENTRY_W-1:0]          w_ram_wdata;
    logic                        w_out_load;
    t_cordic_ctl                 w_cordic_ctl;
    t_cordic_sts                 w_cordic_sts;

    pbnp_cfg #(
        .COORD_BITS(COORD_BITS)
    ) u_cfg (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .o_min_range_sq (w_min_range_sq)
    );

    pbnp_cordic #(
        .COORD_BITS(COORD_BITS),
        .ANGLE_BITS(ANGLE_BITS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_cordic_ctl),
        .i_x     (r_x),
        .i_y     (r_y),
        .o_sts   (w_cordic_sts),
        .o_angle (w_angle)
    );

    pbnp_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(BIN_COUNT)
    ) u_bin_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_addr  (w_ram_addr),
        .i_wdata (w_ram_wdata),
        .o_rdata (w_rdata)
    );

    assign w_ax = r_x[COORD_BITS-1] ? COORD_BITS'(-r_x) : COORD_BITS'(r_x);
    assign w_ay = r_y[COORD_BITS-1] ? COORD_BITS'(-r_y) : COORD_BITS'(r_y);
    assign w_xx = w_ax * w_ax;
    assign w_yy = w_ay * w_ay;
    assign w_skip = (r_range <= w_min_range_sq);

    assign w_bin_raw = r_prod[ANGLE_BITS +: BIN_CW];
    assign w_bin = (w_bin_raw >= BIN_CW'(BIN_COUNT)) ? BIN_W'(BIN_COUNT - 1) : BIN_W'(w_bin_raw);

    assign w_rd_range = w_rdata[ENTRY_W-1 -: RANGE_W];
    assign w_better   = (r_range < w_rd_range);
    assign w_filled   = !r_oob && (w_rd_range != {RANGE_W{1'b1}});

    assign w_cordic_ctl.start = (r_state == ST_CHECK) && !w_skip;

    assign w_ram_we = (r_state == ST_CLEAR)
                   || ((r_state == ST_UPDATE) && (r_cmd == CMD_INSERT) && w_better);
    assign w_ram_addr  = (r_state == ST_CLEAR) ? r_clr_addr : r_bin;
    assign w_ram_wdata = (r_state == ST_CLEAR) ? EMPTY_ENTRY : {r_range, r_x, r_y, r_z};

    assign w_out_load = (r_state == ST_RESULT) && (!r_out_valid || i_out_ready);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_clr_addr == BIN_W'(BIN_COUNT - 1)) begin
                    n_state = r_clr_cmd ? ST_RESULT : ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    case (i_command)
                        CMD_INSERT: n_state = ST_SQUARE;
                        CMD_READ:   n_state = ST_LOOKUP;
                        CMD_CLEAR:  n_state = ST_CLEAR;
                        default:    n_state = ST_RESULT;
                    endcase
                end
            end
            ST_SQUARE: n_state = ST_SUM;
            ST_SUM:    n_state = ST_CHECK;
            ST_CHECK:  n_state = w_skip ? ST_RESULT : ST_CORDIC;
            ST_CORDIC: begin
                if (w_cordic_sts.done) begin
                    n_state = ST_BIN;
                end
            end
            ST_BIN:    n_state = ST_LOOKUP;
            ST_LOOKUP: n_state = ST_UPDATE;
            ST_UPDATE: n_state = ST_RESULT;
            ST_RESULT: begin
                if (w_out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default:   n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_clr_cmd   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) begin
                if (r_clr_addr == BIN_W'(BIN_COUNT - 1)) begin
                    r_clr_addr <= '0;
                end else begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                end
            end
            if ((r_state == ST_IDLE) && i_in_valid) begin
                r_clr_cmd <= (i_command == CMD_CLEAR);
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    r_cmd          <= i_command;
                    r_x            <= i_x_coord;
                    r_y            <= i_y_coord;
                    r_z            <= i_z_coord;
                    r_bin          <= BIN_W'(i_bin_index);
                    r_oob          <= (CMPW'(i_bin_index) >= CMPW'(BIN_COUNT));
                    r_res_accepted <= 1'b0;
                    r_res_filled   <= 1'b0;
                    r_res_x        <= '0;
                    r_res_y        <= '0;
                    r_res_z        <= '0;
                    r_res_range    <= '0;
                end
            end
            ST_SQUARE: begin
                r_xx <= w_xx;
                r_yy <= w_yy;
            end
            ST_SUM: begin
                r_range <= r_xx + r_yy;
            end
            ST_CORDIC: begin
                if (w_cordic_sts.done) begin
                    r_prod <= PROD_W'(w_angle) * PROD_W'(BIN_COUNT);
                end
            end
            ST_BIN: begin
                r_bin <= w_bin;
            end
            ST_UPDATE: begin
                if (r_cmd == CMD_INSERT) begin
                    r_res_accepted <= w_better;
                end else if (w_filled) begin
                    r_res_filled <= 1'b1;
                    r_res_range  <= w_rd_range;
                    r_res_x      <= w_rdata[3*COORD_BITS-1 -: COORD_BITS];
                    r_res_y      <= w_rdata[2*COORD_BITS-1 -: COORD_BITS];
                    r_res_z      <= w_rdata[COORD_BITS-1:0];
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_accepted <= r_res_accepted;
            r_out_filled   <= r_res_filled;
            r_out_x        <= r_res_x;
            r_out_y        <= r_res_y;
            r_out_z        <= r_res_z;
            r_out_range    <= r_res_range;
        end
    end

    assign o_in_ready         = (r_state == ST_IDLE);
    assign o_out_valid        = r_out_valid;
    assign o_accepted         = r_out_accepted;
    assign o_bin_filled       = r_out_filled;
    assign o_nearest_x        = r_out_x;
    assign o_nearest_y        = r_out_y;
    assign o_nearest_z        = r_out_z;
    assign o_nearest_range_sq = r_out_range;

    `PBNP_ASSERT_IMPL(a_insert_beat_zero, i_clk, i_rst_n, o_out_valid && o_accepted, !o_bin_filled && o_nearest_range_sq == '0, "insert beat carries bin data")
    `PBNP_ASSERT_IMPL(a_empty_beat_zero, i_clk, i_rst_n, o_out_valid && !o_bin_filled, o_nearest_x == '0 && o_nearest_y == '0 && o_nearest_z == '0 && o_nearest_range_sq == '0, "empty beat carries data")
    `PBNP_ASSERT_IMPL(a_cordic_only_in_state, i_clk, i_rst_n, r_state != ST_CORDIC, !w_cordic_sts.busy, "cordic busy outside its state")
    `PBNP_ASSERT_NEXT(a_clear_sweeps, i_clk, i_rst_n, r_state == ST_CLEAR && r_clr_addr != BIN_W'(BIN_COUNT - 1), r_state == ST_CLEAR && r_clr_addr == $past(r_clr_addr) + 1'b1, "clear sweep broke off")

endmodule

[sv/pbnp_ram.sv]
// ----------------------------------------------------------------------------
// pbnp_ram
// generic single-port ram with registered read data
// ----------------------------------------------------------------------------
module pbnp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_addr,
    input  logic [WIDTH-1:0] i_wdata,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

[sv/pbnp_cfg.sv]
// ----------------------------------------------------------------------------
// pbnp_cfg
// apb register block holding the minimum squared range threshold
// ----------------------------------------------------------------------------
module pbnp_cfg #(
    parameter int COORD_BITS = pbnp_pkg::COORD_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [pbnp_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [pbnp_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [pbnp_pkg::CFG_DATA_W-1:0] prdata,
    output logic                            pready,
    output logic [2*COORD_BITS-1:0]         o_min_range_sq
);
    import pbnp_pkg::*;

    localparam int RANGE_W = 2 * COORD_BITS;

    logic [RANGE_W-1:0] r_min_range_sq;
    logic               w_sel_min;

    assign w_sel_min = (paddr[CFG_ADDR_W-1] == REG_MIN_RANGE_SQ);
    assign pready    = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_range_sq <= '0;
        end else if (psel && penable && pwrite && pready && w_sel_min) begin
            r_min_range_sq <= pwdata[RANGE_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (w_sel_min) begin
            prdata = CFG_DATA_W'(r_min_range_sq);
        end
    end

    assign o_min_range_sq = r_min_range_sq;

endmodule

[sv/pbnp_cordic.sv]
// ----------------------------------------------------------------------------
// pbnp_cordic
// vectoring cordic, one shared shift/add stage iterated over the atan table entries
// ----------------------------------------------------------------------------
`include "polar_bin_nearest_point_core_defines.svh"

module pbnp_cordic #(
    parameter int COORD_BITS = pbnp_pkg::COORD_BITS_DEF,
    parameter int ANGLE_BITS = pbnp_pkg::ANGLE_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  pbnp_pkg::t_cordic_ctl        i_ctl,
    input  logic signed [COORD_BITS-1:0] i_x,
    input  logic signed [COORD_BITS-1:0] i_y,
    output pbnp_pkg::t_cordic_sts        o_sts,
    output logic [ANGLE_BITS-1:0]        o_angle
);
    import pbnp_pkg::*;

    localparam int XW = COORD_BITS + 3;

    logic signed [XW-1:0] r_x;
    logic signed [XW-1:0] r_y;
    logic signed [XW-1:0] w_x_ext;
    logic signed [XW-1:0] w_y_ext;
    logic signed [XW-1:0] w_dx;
    logic signed [XW-1:0] w_dy;
    logic [31:0]          r_acc;
    logic [31:0]          w_atan;
    logic [ITER_W-1:0]    r_iter;
    logic                 r_busy;
    logic                 r_done;

    assign w_x_ext = {{3{i_x[COORD_BITS-1]}}, i_x};
    assign w_y_ext = {{3{i_y[COORD_BITS-1]}}, i_y};
    assign w_dx    = r_y >>> r_iter;
    assign w_dy    = r_x >>> r_iter;
    assign w_atan  = atan_turn(r_iter);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_iter <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_iter <= '0;
            end else if (r_busy) begin
                r_iter <= r_iter + 1'b1;
                if (r_iter == ITER_W'(CORDIC_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            // left half plane: mirror through the origin, add half a turn
            if (w_x_ext[XW-1]) begin
                r_x   <= -w_x_ext;
                r_y   <= -w_y_ext;
                r_acc <= ACC_START + ACC_START;
            end else begin
                r_x   <= w_x_ext;
                r_y   <= w_y_ext;
                r_acc <= ACC_START;
            end
        end else if (r_busy) begin
            if (!r_y[XW-1]) begin
                r_x   <= r_x + w_dx;
                r_y   <= r_y - w_dy;
                r_acc <= r_acc + w_atan;
            end else begin
                r_x   <= r_x - w_dx;
                r_y   <= r_y + w_dy;
                r_acc <= r_acc - w_atan;
            end
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_angle    = r_acc[31 -: ANGLE_BITS];

    `PBNP_ASSERT_NEXT(a_start_runs, i_clk, i_rst_n, i_ctl.start, r_busy && r_iter == '0, "cordic did not start")
    `PBNP_ASSERT_IMPL(a_no_restart, i_clk, i_rst_n, i_ctl.start, !r_busy && !r_done, "cordic restarted while running")
    `PBNP_ASSERT_NEXT(a_done_after_last, i_clk, i_rst_n, r_busy && r_iter == ITER_W'(CORDIC_STEPS - 1), r_done && !r_busy, "cordic missed its last step")

endmodule
